/* rtl/pidgt_pkg.sv */
package pidgt_pkg;

   // Field and register widths.
   localparam int unsigned OPCODE_W   = 2;
   localparam int unsigned VALUE_W    = 32;
   localparam int unsigned CSR_DATA_W = 47;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned GAIN_COUNT = 3;

   // Item opcodes.
   localparam logic [OPCODE_W-1:0] OP_INIT   = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_SAMPLE = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_TUNE   = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_KP_INIT     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KI_INIT     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KD_INIT     = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LARGE_ERROR = 2'd3;

   // Gain selection codes, also the lane of each gain.
   localparam logic [1:0] SEL_P = 2'd0;
   localparam logic [1:0] SEL_I = 2'd1;
   localparam logic [1:0] SEL_D = 2'd2;

   // Reset value of the large error limit (1000.0 with 16 fraction bits).
   localparam logic [CSR_DATA_W-1:0] LARGE_ERROR_RESET = 47'd65536000;

   typedef struct packed {
      logic [OPCODE_W-1:0]       opcode;
      logic signed [VALUE_W-1:0] cross_error;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] control_value;
      logic signed [VALUE_W-1:0] gain_p;
      logic signed [VALUE_W-1:0] gain_i;
      logic signed [VALUE_W-1:0] gain_d;
   } rsp_type;

endpackage

/* rtl/pid_controller_with_gain_tuning.sv */
// PID controller with coordinate-ascent gain tuning.
//
// Items arrive on the req_ channel (valid/ready) and carry an opcode: init
// loads the gains from the csr_ registers, sample takes one error value and
// produces a control value, tune performs one tuning step on the gains.
// Every item yields exactly one result on the rsp_ channel, carrying the
// control value (zero for anything but sample) and the gains after the item.
//
// One item is accepted per cycle while the result side does not stall. An
// accepted item waits in the input register, the controller state is updated
// in the state stage, then the three products and their combination run
// through a multiply stage, a term stage and the result register. The state
// update loop closes within its stage, so items never wait on each other.
//
// When the receiver stalls, the stages ahead of the result register keep
// filling, and the input stays ready until every stage holds an item.
// Synchronous reset empties the pipeline, sets the configuration registers
// to their reset values and brings the controller state to that of an init.
// Gain writes apply at the next init item, limit writes at the next tune item.
module pid_controller_with_gain_tuning #(
   parameter int unsigned FRACTION_BITS = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  pidgt_pkg::req_type                       req_data,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output pidgt_pkg::rsp_type                       rsp_data,
   input  logic                                     csr_write_enable,
   input  logic [pidgt_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [pidgt_pkg::CSR_DATA_W-1:0]         csr_write_data
);

   localparam int unsigned N = pidgt_pkg::GAIN_COUNT;
   localparam int SMALL_ERR_INT = ((1 << FRACTION_BITS) + 500) / 1000;
   localparam logic signed [31:0] SMALL_ERR = 32'(SMALL_ERR_INT);
   localparam logic signed [47:0] BEST_INIT = 48'(64'(9999) << FRACTION_BITS);
   localparam logic signed [79:0] CLAMP_POS = 80'sd1 <<< 60;
   localparam logic signed [79:0] CLAMP_NEG = -(80'sd1 <<< 60);
   localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;

   // Saturate a 34-bit signed value to 32 bits.
   function automatic logic signed [31:0] sat32_34(input logic signed [33:0] v);
      if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
         return v[31:0];
      end
      return v[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
   endfunction

   // Saturate a 64-bit signed value to 32 bits.
   function automatic logic signed [31:0] sat32_64(input logic signed [63:0] v);
      if ((&v[63:31]) || !(|v[63:31])) begin
         return v[31:0];
      end
      return v[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
   endfunction

   // Saturate a 49-bit signed value to 48 bits.
   function automatic logic signed [47:0] sat48_49(input logic signed [48:0] v);
      if (v[48] == v[47]) begin
         return v[47:0];
      end
      return v[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
   endfunction

   // Unsigned division by ten through the reciprocal, exact for 32-bit input.
   function automatic logic [31:0] div10(input logic [31:0] x);
      logic [63:0] prod;
      prod = {32'd0, x} * {32'd0, DIV10_RECIP};
      return 32'(prod[63:35]);
   endfunction

   // Handshake state of the pipeline.
   logic in_valid_ff, st_valid_ff, mul_valid_ff, trm_valid_ff, rsp_valid_ff;
   logic in_free, st_free, mul_free, trm_free, rsp_free;

   // Configuration registers and the precomputed initial steps.
   logic signed [31:0] cfg_gain_ff [N];
   logic [46:0]        limit_ff;
   logic signed [31:0] init_step_ff [N];
   logic signed [31:0] init_step_in [N];

   // Controller state.
   logic signed [31:0] prev_err_ff, prev_err_in;
   logic signed [47:0] sum_ff, sum_in;
   logic signed [31:0] gain_ff [N];
   logic signed [31:0] gain_in [N];
   logic signed [31:0] step_ff [N];
   logic signed [31:0] step_in [N];
   logic signed [47:0] best_ff, best_in;
   logic [1:0]         sel_ff, sel_in;
   logic               up_ff, up_in;

   // Pipeline payload.
   pidgt_pkg::req_type in_data_ff;
   logic               st_sample_ff, st_sample_in;
   logic signed [31:0] st_err_ff, st_diff_ff, st_diff_in;
   logic signed [47:0] st_sum_ff;
   logic signed [31:0] st_gain_ff [N];
   logic               mul_sample_ff;
   logic signed [63:0] mul_p_ff, mul_p_in, mul_d_ff, mul_d_in;
   logic signed [55:0] mul_ihi_ff, mul_ihi_in;
   logic signed [56:0] mul_ilo_ff, mul_ilo_in;
   logic signed [31:0] mul_gain_ff [N];
   logic               trm_sample_ff;
   logic signed [61:0] trm_p_ff, trm_p_in, trm_d_ff, trm_d_in, trm_i_ff, trm_i_in;
   logic signed [31:0] trm_gain_ff [N];
   pidgt_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // Tuning decisions and the stepped value of the selected lane.
   logic               fire;
   logic               tune_big, tune_better, tune_down;
   logic [1:0]         sel_next;
   logic signed [31:0] step_sel;
   logic [31:0]        step_mag, step_q, step_qx10;
   logic               step_rem_nz;
   logic [32:0]        step_m11, step_m9;
   logic signed [31:0] step_up, step_dn;
   logic signed [31:0] err;
   logic signed [47:0] sum_acc;

   // A stage takes a new item when it is empty or its item moves on.
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign trm_free  = !trm_valid_ff || rsp_free;
   assign mul_free  = !mul_valid_ff || trm_free;
   assign st_free   = !st_valid_ff || mul_free;
   assign in_free   = !in_valid_ff || st_free;
   assign req_ready = in_free;
   assign fire      = in_valid_ff && st_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         st_valid_ff  <= 1'b0;
         mul_valid_ff <= 1'b0;
         trm_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (in_free) in_valid_ff <= req_valid;
         if (st_free) st_valid_ff <= in_valid_ff;
         if (mul_free) mul_valid_ff <= st_valid_ff;
         if (trm_free) trm_valid_ff <= mul_valid_ff;
         if (rsp_free) rsp_valid_ff <= trm_valid_ff;
      end
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_gain_ff[pidgt_pkg::SEL_P] <= '0;
         cfg_gain_ff[pidgt_pkg::SEL_I] <= '0;
         cfg_gain_ff[pidgt_pkg::SEL_D] <= '0;
         limit_ff <= pidgt_pkg::LARGE_ERROR_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            pidgt_pkg::CSR_KP_INIT: begin
               cfg_gain_ff[pidgt_pkg::SEL_P] <= $signed(csr_write_data[31:0]);
            end
            pidgt_pkg::CSR_KI_INIT: begin
               cfg_gain_ff[pidgt_pkg::SEL_I] <= $signed(csr_write_data[31:0]);
            end
            pidgt_pkg::CSR_KD_INIT: begin
               cfg_gain_ff[pidgt_pkg::SEL_D] <= $signed(csr_write_data[31:0]);
            end
            pidgt_pkg::CSR_LARGE_ERROR: begin
               limit_ff <= csr_write_data;
            end
            default: begin
            end
         endcase
      end
   end

   // Initial steps are the configured gains divided by ten, truncated toward
   // zero. They are registered behind the configuration registers.
   for (genvar k = 0; k < N; k++) begin : g_init_step
      logic [31:0] mag;
      logic [31:0] quo;
      assign mag = cfg_gain_ff[k][31] ? 32'(-cfg_gain_ff[k]) : cfg_gain_ff[k];
      assign quo = div10(mag);
      assign init_step_in[k] = cfg_gain_ff[k][31] ? $signed(-quo) : $signed(quo);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_step_ff[pidgt_pkg::SEL_P] <= '0;
         init_step_ff[pidgt_pkg::SEL_I] <= '0;
         init_step_ff[pidgt_pkg::SEL_D] <= '0;
      end else begin
         init_step_ff <= init_step_in;
      end
   end

   // Sample arithmetic: saturated difference and the running sum, which is
   // cleared whenever the error falls below the small error threshold.
   assign err        = in_data_ff.cross_error;
   assign st_diff_in = sat32_34(34'(err) - 34'(prev_err_ff));
   assign sum_acc    = sat48_49(49'(sum_ff) + 49'(err));

   // Tuning decisions taken from the current state.
   assign tune_big    = $signed({best_ff[47], best_ff}) > $signed({2'b00, limit_ff});
   assign tune_better = sum_ff < best_ff;
   assign tune_down   = !tune_better && !up_ff;

   always_comb begin
      case (sel_ff)
         pidgt_pkg::SEL_P: begin
            sel_next = pidgt_pkg::SEL_I;
            step_sel = step_ff[pidgt_pkg::SEL_P];
         end
         pidgt_pkg::SEL_I: begin
            sel_next = pidgt_pkg::SEL_D;
            step_sel = step_ff[pidgt_pkg::SEL_I];
         end
         default: begin
            sel_next = pidgt_pkg::SEL_P;
            step_sel = step_ff[pidgt_pkg::SEL_D];
         end
      endcase
   end

   // Step scaling by 1.1 and 0.9: for a magnitude m, trunc(11m/10) is
   // m + m/10 and trunc(9m/10) is m - ceil(m/10).
   assign step_mag    = step_sel[31] ? 32'(-step_sel) : step_sel;
   assign step_q      = div10(step_mag);
   assign step_qx10   = {step_q[28:0], 3'b000} + {step_q[30:0], 1'b0};
   assign step_rem_nz = step_qx10 != step_mag;
   assign step_m11    = {1'b0, step_mag} + {1'b0, step_q};
   assign step_m9     = {1'b0, step_mag} - {1'b0, step_q} - {32'd0, step_rem_nz};
   assign step_up     = sat32_34(step_sel[31] ? -$signed({1'b0, step_m11})
                                              : $signed({1'b0, step_m11}));
   assign step_dn     = sat32_34(step_sel[31] ? -$signed({1'b0, step_m9})
                                              : $signed({1'b0, step_m9}));

   // Next value of the scalar state.
   always_comb begin
      prev_err_in  = prev_err_ff;
      sum_in       = sum_ff;
      best_in      = best_ff;
      sel_in       = sel_ff;
      up_in        = up_ff;
      st_sample_in = 1'b0;
      case (in_data_ff.opcode)
         pidgt_pkg::OP_INIT: begin
            prev_err_in = '0;
            sum_in      = '0;
            best_in     = BEST_INIT;
            sel_in      = pidgt_pkg::SEL_P;
            up_in       = 1'b1;
         end
         pidgt_pkg::OP_SAMPLE: begin
            st_sample_in = 1'b1;
            prev_err_in  = err;
            sum_in       = (err < SMALL_ERR) ? 48'sd0 : sum_acc;
         end
         pidgt_pkg::OP_TUNE: begin
            if (tune_big) begin
               best_in = sum_ff;
            end else if (tune_better) begin
               best_in = sum_ff;
               sel_in  = sel_next;
               up_in   = 1'b1;
            end else if (up_ff) begin
               up_in = 1'b0;
            end else begin
               sel_in = sel_next;
               up_in  = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Per-gain lanes: each lane decides its own gain and step.
   for (genvar k = 0; k < N; k++) begin : g_lane
      logic signed [31:0] plus_c, minus2_c, gain_nx, step_nx;
      logic               own_sel, own_next;
      assign plus_c   = sat32_34(34'(gain_ff[k]) + 34'(step_ff[k]));
      assign minus2_c = sat32_34(34'(gain_ff[k]) - (34'(step_ff[k]) <<< 1));
      assign own_sel  = sel_ff == 2'(k);
      assign own_next = sel_in == 2'(k);

      always_comb begin
         gain_nx = gain_ff[k];
         step_nx = step_ff[k];
         case (in_data_ff.opcode)
            pidgt_pkg::OP_INIT: begin
               gain_nx = cfg_gain_ff[k];
               step_nx = init_step_ff[k];
            end
            pidgt_pkg::OP_TUNE: begin
               if (tune_big) begin
                  if (2'(k) == pidgt_pkg::SEL_P) gain_nx = plus_c;
               end else begin
                  // The gain now selected is probed; a gain left after a failed
                  // probe in both directions keeps its original value.
                  if (own_next) begin
                     gain_nx = up_in ? plus_c : minus2_c;
                  end else if (tune_down && own_sel) begin
                     gain_nx = plus_c;
                  end
                  if (own_sel && tune_better) begin
                     step_nx = step_up;
                  end else if (own_sel && tune_down) begin
                     step_nx = step_dn;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      assign gain_in[k] = gain_nx;
      assign step_in[k] = step_nx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_err_ff <= '0;
         sum_ff      <= '0;
         best_ff     <= BEST_INIT;
         sel_ff      <= pidgt_pkg::SEL_P;
         up_ff       <= 1'b1;
         for (int k = 0; k < N; k++) begin
            gain_ff[k] <= '0;
            step_ff[k] <= '0;
         end
      end else if (fire) begin
         prev_err_ff <= prev_err_in;
         sum_ff      <= sum_in;
         best_ff     <= best_in;
         sel_ff      <= sel_in;
         up_ff       <= up_in;
         gain_ff     <= gain_in;
         step_ff     <= step_in;
      end
   end

   // Products: the sum is split into an upper and a lower half.
   assign mul_p_in   = st_gain_ff[pidgt_pkg::SEL_P] * st_err_ff;
   assign mul_d_in   = st_gain_ff[pidgt_pkg::SEL_D] * st_diff_ff;
   assign mul_ihi_in = st_gain_ff[pidgt_pkg::SEL_I] * $signed(st_sum_ff[47:24]);
   assign mul_ilo_in = st_gain_ff[pidgt_pkg::SEL_I] * $signed({1'b0, st_sum_ff[23:0]});

   // Terms: each product floored to the fraction bits; the integral term is
   // clamped to plus or minus 2^60.
   logic signed [79:0] prod_i_full, prod_i_floor;
   assign prod_i_full  = (80'(mul_ihi_ff) <<< 24) + 80'(mul_ilo_ff);
   assign prod_i_floor = prod_i_full >>> FRACTION_BITS;
   assign trm_p_in     = 62'(mul_p_ff >>> FRACTION_BITS);
   assign trm_d_in     = 62'(mul_d_ff >>> FRACTION_BITS);

   always_comb begin
      if (prod_i_floor > CLAMP_POS) begin
         trm_i_in = 62'(CLAMP_POS);
      end else if (prod_i_floor < CLAMP_NEG) begin
         trm_i_in = 62'(CLAMP_NEG);
      end else begin
         trm_i_in = 62'(prod_i_floor);
      end
   end

   // Result: negated sum of the terms, saturated.
   logic signed [63:0] term_total;
   assign term_total = 64'(trm_p_ff) + 64'(trm_d_ff) + 64'(trm_i_ff);

   always_comb begin
      rsp_data_in.control_value = trm_sample_ff ? sat32_64(-term_total) : 32'sd0;
      rsp_data_in.gain_p        = trm_gain_ff[pidgt_pkg::SEL_P];
      rsp_data_in.gain_i        = trm_gain_ff[pidgt_pkg::SEL_I];
      rsp_data_in.gain_d        = trm_gain_ff[pidgt_pkg::SEL_D];
   end

   // Payload registers of the stages.
   always_ff @(posedge clock) begin
      if (in_free) in_data_ff <= req_data;
      if (st_free) begin
         st_sample_ff <= st_sample_in;
         st_err_ff    <= err;
         st_diff_ff   <= st_diff_in;
         st_sum_ff    <= sum_in;
         st_gain_ff   <= gain_in;
      end
      if (mul_free) begin
         mul_sample_ff <= st_sample_ff;
         mul_p_ff      <= mul_p_in;
         mul_d_ff      <= mul_d_in;
         mul_ihi_ff    <= mul_ihi_in;
         mul_ilo_ff    <= mul_ilo_in;
         mul_gain_ff   <= st_gain_ff;
      end
      if (trm_free) begin
         trm_sample_ff <= mul_sample_ff;
         trm_p_ff      <= trm_p_in;
         trm_d_ff      <= trm_d_in;
         trm_i_ff      <= trm_i_in;
         trm_gain_ff   <= mul_gain_ff;
      end
      if (rsp_free) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* rtl/pidgt_checker.sv */
module pidgt_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input pidgt_pkg::rsp_type rsp_data
);

   // Gains of the last delivered item.
   logic               have_last_ff;
   logic signed [31:0] last_p_ff, last_i_ff, last_d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         have_last_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         have_last_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         last_p_ff <= rsp_data.gain_p;
         last_i_ff <= rsp_data.gain_i;
         last_d_ff <= rsp_data.gain_d;
      end
   end

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or vanished");

   // Reset empties the pipeline and opens the input.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

   // With no result waiting every stage can move, so the input is ready.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked while no result is waiting");

   // A sample item, the only kind with a nonzero control value, leaves the
   // gains as the previous item left them.
   a_sample_keeps_gains: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && have_last_ff && rsp_data.control_value != 0
      |-> rsp_data.gain_p == last_p_ff && rsp_data.gain_i == last_i_ff
          && rsp_data.gain_d == last_d_ff)
      else $error("gains changed by a sample item");

endmodule

bind pid_controller_with_gain_tuning pidgt_checker u_pidgt_checker (.*);

/* tb/pid_controller_with_gain_tuning_tb.sv */
module pid_controller_with_gain_tuning_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = 16;
   localparam logic [pidgt_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

   // Fixed-point limits used by the controller.
   localparam longint SMALL_ERROR = ((64'sd1 <<< FRAC) + 500) / 1000;
   localparam longint BEST_START = 64'sd9999 <<< FRAC;
   localparam longint SUM_MAX = (64'sd1 <<< 47) - 1;
   localparam longint SUM_MIN = -(64'sd1 <<< 47);
   localparam longint TERM_LIMIT = 64'sd1 <<< 60;

   // Run shape.
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 130;
   localparam int SATURATION_SAMPLES = 100;
   localparam int PRESSURE_ITEMS = 40;
   localparam int LONG_STALL = 300;
   localparam int DRAIN_GAP = 8;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int REPORT_LIMIT = 10;

   // Tracks the controller state and the outputs still awaited from the block.
   class pid_checker;
      longint kp_start, ki_start, kd_start, error_limit;
      longint last_error, error_delta, error_total, best_total;
      longint gain[pidgt_pkg::GAIN_COUNT];
      longint step[pidgt_pkg::GAIN_COUNT];
      int sel;
      bit going_up;
      pidgt_pkg::rsp_type due_outputs[$];
      int mismatches;

      function longint clamp32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function longint clamp48(longint v);
         if (v > SUM_MAX) return SUM_MAX;
         if (v < SUM_MIN) return SUM_MIN;
         return v;
      endfunction

      // Product floored to the fraction width and held within the term range.
      function longint scaled_product(longint a, longint b);
         logic signed [127:0] p;
         p = a;
         p = p * b;
         p = p >>> FRAC;
         if (p > TERM_LIMIT) return TERM_LIMIT;
         if (p < -TERM_LIMIT) return -TERM_LIMIT;
         return longint'(p);
      endfunction

      function void restart();
         gain[pidgt_pkg::SEL_P] = kp_start;
         gain[pidgt_pkg::SEL_I] = ki_start;
         gain[pidgt_pkg::SEL_D] = kd_start;
         for (int k = 0; k < pidgt_pkg::GAIN_COUNT; k++) step[k] = gain[k] / 10;
         last_error = 0;
         error_delta = 0;
         error_total = 0;
         best_total = BEST_START;
         sel = pidgt_pkg::SEL_P;
         going_up = 1'b1;
      endfunction

      function void reset_state();
         kp_start = 0;
         ki_start = 0;
         kd_start = 0;
         error_limit = longint'(pidgt_pkg::LARGE_ERROR_RESET);
         mismatches = 0;
         restart();
      endfunction

      function void write_register(logic [pidgt_pkg::CSR_INDEX_W-1:0] idx,
                                   logic [pidgt_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            pidgt_pkg::CSR_KP_INIT: kp_start = $signed(data[31:0]);
            pidgt_pkg::CSR_KI_INIT: ki_start = $signed(data[31:0]);
            pidgt_pkg::CSR_KD_INIT: kd_start = $signed(data[31:0]);
            pidgt_pkg::CSR_LARGE_ERROR: error_limit = longint'(data);
            default: ;
         endcase
      endfunction

      // One coordinate-ascent step, with the running sum as the error measure.
      function void tune_gains();
         longint measure;
         int s;
         measure = error_total;
         if (best_total > error_limit) begin
            best_total = measure;
            gain[pidgt_pkg::SEL_P] = clamp32(gain[pidgt_pkg::SEL_P] + step[pidgt_pkg::SEL_P]);
            return;
         end
         s = sel;
         if (measure < best_total) begin
            best_total = measure;
            step[s] = clamp32(step[s] * 11 / 10);
            sel = (s + 1) % pidgt_pkg::GAIN_COUNT;
            going_up = 1'b1;
         end else if (going_up) begin
            going_up = 1'b0;
         end else begin
            gain[s] = clamp32(gain[s] + step[s]);
            step[s] = clamp32(step[s] * 9 / 10);
            sel = (s + 1) % pidgt_pkg::GAIN_COUNT;
            going_up = 1'b1;
         end
         s = sel;
         if (going_up) gain[s] = clamp32(gain[s] + step[s]);
         else gain[s] = clamp32(gain[s] - 2 * step[s]);
      endfunction

      // Advances the state for an accepted item and queues the output it causes.
      function void note_item(pidgt_pkg::req_type item);
         longint e, terms;
         pidgt_pkg::rsp_type out;
         out.control_value = '0;
         case (item.opcode)
            pidgt_pkg::OP_INIT: restart();
            pidgt_pkg::OP_SAMPLE: begin
               e = $signed(item.cross_error);
               error_delta = clamp32(e - last_error);
               last_error = e;
               error_total = clamp48(error_total + e);
               if (e < SMALL_ERROR) error_total = 0;
               terms = scaled_product(gain[pidgt_pkg::SEL_P], e)
                     + scaled_product(gain[pidgt_pkg::SEL_D], error_delta)
                     + scaled_product(gain[pidgt_pkg::SEL_I], error_total);
               out.control_value = 32'(clamp32(-terms));
            end
            pidgt_pkg::OP_TUNE: tune_gains();
            default: ;
         endcase
         out.gain_p = 32'(gain[pidgt_pkg::SEL_P]);
         out.gain_i = 32'(gain[pidgt_pkg::SEL_I]);
         out.gain_d = 32'(gain[pidgt_pkg::SEL_D]);
         due_outputs.push_back(out);
      endfunction

      function void compare(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: %s mismatch, expected %0d, got %0d", $time, field,
                        $signed(want), $signed(got));
         end
      endfunction

      function void check_result(pidgt_pkg::rsp_type got);
         pidgt_pkg::rsp_type want;
         if (due_outputs.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: result with nothing awaited, control %0d", $time,
                        $signed(got.control_value));
            return;
         end
         want = due_outputs.pop_front();
         compare("control_value", want.control_value, got.control_value);
         compare("gain_p", want.gain_p, got.gain_p);
         compare("gain_i", want.gain_i, got.gain_i);
         compare("gain_d", want.gain_d, got.gain_d);
      endfunction

      function int pending();
         return due_outputs.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   pidgt_pkg::req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   pidgt_pkg::rsp_type rsp_data;
   logic csr_write_enable;
   logic [pidgt_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [pidgt_pkg::CSR_DATA_W-1:0] csr_write_data;

   pid_checker sb;
   bit quiet_run;
   bit stall_request;

   pid_controller_with_gain_tuning #(
      .FRACTION_BITS(FRAC)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result side: random stalls, one long hold-off on request, none in the quiet part.
   initial begin : result_sink
      int remaining;
      bit level;
      rsp_ready <= 1'b0;
      remaining = 0;
      level = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_request) begin
            stall_request = 1'b0;
            level = 1'b0;
            remaining = LONG_STALL;
         end else if (remaining == 0) begin
            if (quiet_run || !level) begin
               level = 1'b1;
               remaining = quiet_run ? 1 : $urandom_range(1, 40);
            end else begin
               level = 1'b0;
               remaining = $urandom_range(1, 13);
            end
         end
         remaining--;
         rsp_ready <= level;
      end
   end

   // Every accepted result is checked against the oldest awaited output.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_data);
   end

   // The run is abandoned when nothing moves on either channel for too long.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("simulation failed");
      $finish;
   end

   // Offers one item and holds it until the block accepts it.
   task automatic offer_item(input logic [pidgt_pkg::OPCODE_W-1:0] op,
                             input logic [pidgt_pkg::VALUE_W-1:0] err);
      pidgt_pkg::req_type item;
      item.opcode = op;
      item.cross_error = err;
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      sb.note_item(item);
   endtask

   task automatic pause_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic send_item(input logic [pidgt_pkg::OPCODE_W-1:0] op,
                            input logic [pidgt_pkg::VALUE_W-1:0] err);
      if (!quiet_run && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 13));
      offer_item(op, err);
   endtask

   // Waits until every awaited output has arrived and the pipeline is empty.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_GAP) @(posedge clock);
   endtask

   task automatic write_csr(input logic [pidgt_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [pidgt_pkg::CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      sb.write_register(idx, data);
   endtask

   task automatic program_registers(input logic [pidgt_pkg::CSR_DATA_W-1:0] kp,
                                    input logic [pidgt_pkg::CSR_DATA_W-1:0] ki,
                                    input logic [pidgt_pkg::CSR_DATA_W-1:0] kd,
                                    input logic [pidgt_pkg::CSR_DATA_W-1:0] limit);
      write_csr(pidgt_pkg::CSR_KP_INIT, kp);
      write_csr(pidgt_pkg::CSR_KI_INIT, ki);
      write_csr(pidgt_pkg::CSR_KD_INIT, kd);
      write_csr(pidgt_pkg::CSR_LARGE_ERROR, limit);
      csr_write_enable <= 1'b0;
   endtask

   // Mostly modest errors with a positive lean, so that the sum builds up.
   function automatic logic [pidgt_pkg::VALUE_W-1:0] pick_error();
      case ($urandom_range(0, 15))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'($urandom_range(60, 70));
         3, 4: return $urandom();
         default: return 32'($urandom_range(0, 32'h0004_0000)) - 32'h0001_0000;
      endcase
   endfunction

   // Gains sit in the low 32 bits of the data word; the upper bits are left random.
   function automatic logic [pidgt_pkg::CSR_DATA_W-1:0] pick_gain();
      logic [31:0] g;
      case ($urandom_range(0, 7))
         0: g = 32'h7FFF_FFFF;
         1: g = 32'h8000_0000;
         2: g = '0;
         3: g = $urandom();
         default: g = 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
      endcase
      return {15'($urandom()), g};
   endfunction

   function automatic logic [pidgt_pkg::CSR_DATA_W-1:0] pick_limit();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return '1;
         2: return pidgt_pkg::LARGE_ERROR_RESET;
         3: return 47'($urandom_range(0, 32'h0100_0000));
         default: return 47'({$urandom(), $urandom()});
      endcase
   endfunction

   initial begin : stimulus
      int sent;
      int run;
      logic [pidgt_pkg::OPCODE_W-1:0] op;

      sb = new();
      sb.reset_state();
      quiet_run = 1'b0;
      stall_request = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_write_enable <= 1'b0;
      csr_index <= '0;
      csr_write_data <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset gains are zero; the state still moves and the unused opcode is ignored.
      send_item(pidgt_pkg::OP_SAMPLE, 32'h0064_0000);
      send_item(pidgt_pkg::OP_TUNE, '0);
      send_item(OP_UNUSED, 32'hFFFF_FFFF);
      drain();

      // Extreme gains with a limit that never restarts tuning.
      program_registers(47'h0000_7FFF_FFFF, 47'h0000_8000_0000, 47'h0000_0001_0000, '1);
      send_item(pidgt_pkg::OP_INIT, '0);
      send_item(pidgt_pkg::OP_SAMPLE, 32'h7FFF_FFFF);
      send_item(pidgt_pkg::OP_SAMPLE, 32'h8000_0000);
      send_item(pidgt_pkg::OP_SAMPLE, 32'h7FFF_FFFF);
      send_item(pidgt_pkg::OP_SAMPLE, 32'h0000_0041);
      send_item(pidgt_pkg::OP_SAMPLE, 32'h0000_0042);
      send_item(pidgt_pkg::OP_SAMPLE, 32'hFFFF_FFFF);
      send_item(pidgt_pkg::OP_SAMPLE, 32'h0000_0000);
      send_item(pidgt_pkg::OP_SAMPLE, 32'h0003_0000);
      send_item(pidgt_pkg::OP_TUNE, '0);
      send_item(pidgt_pkg::OP_TUNE, '0);
      send_item(pidgt_pkg::OP_SAMPLE, 32'h0003_0000);
      send_item(pidgt_pkg::OP_TUNE, '0);
      send_item(OP_UNUSED, 32'h0001_0000);

      // A run of full-scale errors builds up a large sum and integral term.
      quiet_run = 1'b1;
      send_item(pidgt_pkg::OP_INIT, '0);
      repeat (SATURATION_SAMPLES) offer_item(pidgt_pkg::OP_SAMPLE, 32'h7FFF_FFFF);
      send_item(pidgt_pkg::OP_TUNE, '0);
      send_item(pidgt_pkg::OP_SAMPLE, 32'h7FFF_FFFF);
      quiet_run = 1'b0;
      drain();

      // Most negative gains and a zero limit, so every tune with a positive best restarts.
      program_registers(47'h7FFF_8000_0000, 47'h0000_8000_0000, 47'h0000_8000_0000, '0);
      send_item(pidgt_pkg::OP_INIT, '0);
      send_item(pidgt_pkg::OP_TUNE, '0);
      send_item(pidgt_pkg::OP_SAMPLE, 32'h8000_0000);
      send_item(pidgt_pkg::OP_SAMPLE, 32'h0001_0000);
      send_item(pidgt_pkg::OP_TUNE, '0);
      send_item(pidgt_pkg::OP_TUNE, '0);

      // Random phases: each starts from fresh registers and an init item.
      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         if (phase == 0) program_registers(pick_gain(), pick_gain(), pick_gain(), '1);
         else program_registers(pick_gain(), pick_gain(), pick_gain(), pick_limit());
         quiet_run = (phase == PHASES - 1);
         send_item(pidgt_pkg::OP_INIT, $urandom());

         // Hold the result side off while items keep coming, so the block fills up.
         if (phase == 2) begin
            stall_request = 1'b1;
            repeat (PRESSURE_ITEMS) offer_item(pidgt_pkg::OP_SAMPLE, pick_error());
         end
         // Let everything drain mid-phase before carrying on.
         if (phase == 4) begin
            repeat (20) send_item(pidgt_pkg::OP_SAMPLE, pick_error());
            drain();
         end

         sent = 0;
         while (sent < PHASE_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
               op = 2'($urandom_range(0, 3));
               send_item(op, pick_error());
               if (op != OP_UNUSED) sent++;
            end else begin
               run = $urandom_range(1, 12);
               repeat (run) send_item(pidgt_pkg::OP_SAMPLE, pick_error());
               send_item(pidgt_pkg::OP_TUNE, $urandom());
               sent += run + 1;
            end
         end
      end

      drain();
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
